[design/cpp_pkg.sv]
package cpp_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int COORD_BITS_DEF   = 24;
    localparam int IDX_BITS         = 10;
    localparam int DIST_BITS        = 52;
    localparam int FRAC_BITS        = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_DOT0,
        S_DOT1,
        S_DOT2,
        S_DECIDE,
        S_DIV,
        S_MUL,
        S_DIST0,
        S_DIST1,
        S_DIST2,
        S_UPDATE,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_first;
        logic load_vertex;
        logic diff;
        logic dot;
        logic [1:0] lane;
        logic div_init;
        logic div_step;
        logic mul;
        logic dist_acc;
        logic update;
        logic advance;
        logic reset_best;
        logic single;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic c1_le_zero;
        logic c2_le_c1;
        logic count_full;
    } t_status;

endpackage

[design/cpp_ctrl.sv]
module cpp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_last,
    input  logic             i_out_ready,
    input  cpp_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output cpp_pkg::t_cmd    o_cmd
);
    import cpp_pkg::*;

    t_state r_state, n_state;
    logic   r_have_prev, n_have_prev;
    logic   r_last, n_last;
    logic   r_single, n_single;
    logic [1:0] r_lane, n_lane;
    logic [5:0] r_step, n_step;
    logic   accept;

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
            r_last      <= 1'b0;
            r_single    <= 1'b0;
            r_lane      <= '0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_have_prev <= n_have_prev;
            r_last      <= n_last;
            r_single    <= n_single;
            r_lane      <= n_lane;
            r_step      <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_have_prev = r_have_prev;
        n_last      = r_last;
        n_single    = r_single;
        n_lane      = r_lane;
        n_step      = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_last = i_last;
                    if (!r_have_prev) begin
                        n_single    = i_last;
                        n_have_prev = !i_last;
                        n_state     = i_last ? S_DIFF : S_IDLE;
                    end else begin
                        n_single = 1'b0;
                        if (i_status.count_full) begin
                            n_state = i_last ? S_OUT : S_IDLE;
                            if (i_last) n_have_prev = 1'b0;
                        end else begin
                            n_state = S_DIFF;
                        end
                    end
                end
            end
            S_DIFF:   n_state = S_DOT0;
            S_DOT0:   n_state = S_DOT1;
            S_DOT1:   n_state = S_DOT2;
            S_DOT2:   n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_status.c1_le_zero || i_status.c2_le_c1) begin
                    n_state = S_DIST0;
                end else begin
                    n_state = S_DIV;
                    n_step  = '0;
                end
            end
            S_DIV: begin
                n_step = r_step + 6'd1;
                if (r_step == 6'(FRAC_BITS - 1)) begin
                    n_state = S_MUL;
                    n_lane  = '0;
                end
            end
            S_MUL: begin
                n_lane = r_lane + 2'd1;
                if (r_lane == 2'd2) n_state = S_DIST0;
            end
            S_DIST0:  n_state = S_DIST1;
            S_DIST1:  n_state = S_DIST2;
            S_DIST2:  n_state = S_UPDATE;
            S_UPDATE: begin
                if (r_last) begin
                    n_state     = S_OUT;
                    n_have_prev = 1'b0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        o_cmd.single = r_single;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!r_have_prev) begin
                        o_cmd.load_first = 1'b1;
                        o_cmd.reset_best = 1'b1;
                        o_cmd.single     = i_last;
                    end else if (!i_status.count_full) begin
                        o_cmd.load_vertex = 1'b1;
                        o_cmd.single      = 1'b0;
                    end
                end
            end
            S_DIFF:   o_cmd.diff = 1'b1;
            S_DOT0:   begin o_cmd.dot = 1'b1; o_cmd.lane = 2'd0; end
            S_DOT1:   begin o_cmd.dot = 1'b1; o_cmd.lane = 2'd1; end
            S_DOT2:   begin o_cmd.dot = 1'b1; o_cmd.lane = 2'd2; end
            S_DECIDE: o_cmd.div_init = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_MUL:    begin o_cmd.mul = 1'b1; o_cmd.lane = r_lane; end
            S_DIST0:  begin o_cmd.dist_acc = 1'b1; o_cmd.lane = 2'd0; end
            S_DIST1:  begin o_cmd.dist_acc = 1'b1; o_cmd.lane = 2'd1; end
            S_DIST2:  begin o_cmd.dist_acc = 1'b1; o_cmd.lane = 2'd2; end
            S_UPDATE: begin o_cmd.update = 1'b1; o_cmd.advance = !r_single; end
            S_OUT:    ;
            default:  ;
        endcase
    end

    // a result is only offered at the end of a polyline
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result is pending");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_step < 6'(FRAC_BITS)))
        else $error("divider ran past its step count");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped before it was taken");

endmodule

[design/cpp_dp.sv]
module cpp_dp #(
    parameter int MAX_VERTICES = cpp_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = cpp_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  cpp_pkg::t_cmd                        i_cmd,
    input  logic                                 i_rst_n,
    input  logic signed [COORD_BITS-1:0]         i_vx,
    input  logic signed [COORD_BITS-1:0]         i_vy,
    input  logic signed [COORD_BITS-1:0]         i_vz,
    input  logic signed [COORD_BITS-1:0]         i_qx,
    input  logic signed [COORD_BITS-1:0]         i_qy,
    input  logic signed [COORD_BITS-1:0]         i_qz,
    output cpp_pkg::t_status                     o_status,
    output logic signed [COORD_BITS-1:0]         o_px,
    output logic signed [COORD_BITS-1:0]         o_py,
    output logic signed [COORD_BITS-1:0]         o_pz,
    output logic [cpp_pkg::IDX_BITS-1:0]         o_seg,
    output logic [2*COORD_BITS+3:0]              o_dist
);
    import cpp_pkg::*;

    localparam int DB = COORD_BITS + 1;         // difference width
    localparam int PB = 2 * DB;                  // product width
    localparam int SB = PB + 2;                  // dot sum width
    localparam int DW = 2 * COORD_BITS + 4;      // distance width
    localparam int CB = $clog2(MAX_VERTICES);

    logic signed [COORD_BITS-1:0] r_a [3];
    logic signed [COORD_BITS-1:0] r_b [3];
    logic signed [COORD_BITS-1:0] r_q [3];
    logic signed [COORD_BITS-1:0] r_pt [3];
    logic signed [COORD_BITS-1:0] r_best [3];
    logic signed [DB-1:0] r_v [3];
    logic signed [DB-1:0] r_w [3];
    logic signed [SB-1:0] r_c1, r_c2;
    logic [SB:0] r_rem;
    logic [FRAC_BITS-1:0] r_t;
    logic [DW-1:0] r_dist, r_best_dist;
    logic [CB-1:0] r_count;
    logic [IDX_BITS-1:0] r_best_seg;
    logic r_best_valid;
    logic r_near_a, r_near_b;

    logic [SB:0] rem_sh;
    logic [DB-1:0] mag;
    logic [DB+FRAC_BITS-1:0] prod;
    logic [DB-1:0] rnd;
    logic signed [DB-1:0] dq;
    logic signed [PB-1:0] sq;
    logic [1:0] ln;
    logic signed [DB:0] a_ext;

    assign ln = i_cmd.lane;

    always_comb begin
        rem_sh = {r_rem[SB-1:0], 1'b0};
        mag    = r_v[ln][DB-1] ? DB'(-r_v[ln]) : DB'(r_v[ln]);
        prod   = (DB+FRAC_BITS)'(mag) * (DB+FRAC_BITS)'(r_t)
                 + (DB+FRAC_BITS)'(64'd1 << (FRAC_BITS-1));
        rnd    = prod[DB+FRAC_BITS-1:FRAC_BITS];
        a_ext  = (DB+1)'(r_a[ln]);
        dq     = DB'(r_q[ln]) - DB'(r_pt[ln]);
        sq     = PB'(dq) * PB'(dq);
    end

    always_ff @(posedge i_clk) begin
        // capture vertices
        if (i_cmd.load_first) begin
            r_q[0] <= i_qx; r_q[1] <= i_qy; r_q[2] <= i_qz;
            r_a[0] <= i_vx; r_a[1] <= i_vy; r_a[2] <= i_vz;
            r_b[0] <= i_vx; r_b[1] <= i_vy; r_b[2] <= i_vz;
        end
        if (i_cmd.load_vertex) begin
            r_a <= r_b;
            r_b[0] <= i_vx; r_b[1] <= i_vy; r_b[2] <= i_vz;
        end
        // segment and query offsets
        if (i_cmd.diff) begin
            for (int i = 0; i < 3; i++) begin
                r_v[i] <= DB'(r_b[i]) - DB'(r_a[i]);
                r_w[i] <= DB'(r_q[i]) - DB'(r_a[i]);
            end
            r_c1 <= '0;
            r_c2 <= '0;
        end
        // dot products, one lane a cycle
        if (i_cmd.dot) begin
            r_c1 <= r_c1 + SB'(PB'(r_w[ln]) * PB'(r_v[ln]));
            r_c2 <= r_c2 + SB'(PB'(r_v[ln]) * PB'(r_v[ln]));
        end
        // clamp decision and divider setup
        if (i_cmd.div_init) begin
            r_near_a <= (r_c1 <= 0);
            r_near_b <= (r_c1 > 0) && (r_c2 <= r_c1);
            r_rem    <= (SB+1)'(r_c1);
            r_t      <= '0;
            if (r_c1 <= 0)        r_pt <= r_a;
            else if (r_c2 <= r_c1) r_pt <= r_b;
            r_dist <= '0;
        end
        // restoring division, one quotient bit a cycle
        if (i_cmd.div_step) begin
            if (rem_sh >= (SB+1)'(r_c2)) begin
                r_rem <= rem_sh - (SB+1)'(r_c2);
                r_t   <= {r_t[FRAC_BITS-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_t   <= {r_t[FRAC_BITS-2:0], 1'b0};
            end
        end
        // interpolated point, one lane a cycle
        if (i_cmd.mul) begin
            if (r_v[ln][DB-1])
                r_pt[ln] <= COORD_BITS'(a_ext - (DB+1)'(rnd));
            else
                r_pt[ln] <= COORD_BITS'(a_ext + (DB+1)'(rnd));
        end
        // squared distance
        if (i_cmd.dist_acc)
            r_dist <= r_dist + DW'(sq);
    end

    // best-so-far and segment count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
            r_count      <= '0;
            r_best_seg   <= '0;
            r_best_dist  <= '0;
        end else begin
            if (i_cmd.reset_best) begin
                r_best_valid <= 1'b0;
                r_count      <= '0;
                r_best_seg   <= '0;
                r_best_dist  <= '0;
            end
            if (i_cmd.update) begin
                if (!r_best_valid || r_dist < r_best_dist) begin
                    r_best_valid <= 1'b1;
                    r_best_dist  <= r_dist;
                    r_best_seg   <= IDX_BITS'(r_count);
                    r_best       <= r_pt;
                end
                if (i_cmd.advance) r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_status.c1_le_zero = (r_c1 <= 0);
    assign o_status.c2_le_c1   = (r_c2 <= r_c1);
    assign o_status.count_full = (r_count == CB'(MAX_VERTICES - 1));
    assign o_px   = r_best[0];
    assign o_py   = r_best[1];
    assign o_pz   = r_best[2];
    assign o_seg  = r_best_seg;
    assign o_dist = r_best_dist;

    // clamped and interpolated cases never overlap
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> !(r_near_a || r_near_b))
        else $error("divider used on a clamped segment");
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && i_cmd.single) |-> (r_count == '0))
        else $error("single vertex after segments");
    a_quot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < (SB+1)'(r_c2)))
        else $error("division remainder out of range");

endmodule

[design/closest_point_on_polyline_unit.sv]
// channel | dir | tdata fields (low bit up)                              | tlast
// s_axis  | in  | vertex_x, vertex_y, vertex_z, query_x, query_y, query_z | last_vertex
// m_axis  | out | nearest_x, nearest_y, nearest_z, segment_index,         | -
//         |     |   squared_distance                                      |
// a clamped segment skips the divider; otherwise the 32-step restoring divider
// computes the projection fraction
// reset clears the controller, the segment count and the best-so-far valid flag, index and distance only
// while a result waits for m_axis_tready no vertex is taken
module closest_point_on_polyline_unit #(
    parameter int MAX_VERTICES = cpp_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = cpp_pkg::COORD_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // vertex_x, vertex_y, vertex_z, query_x, query_y, query_z, zero pad
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic           s_axis_tlast,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // nearest_x, nearest_y, nearest_z, segment_index, squared_distance, zero pad
    output logic [((5*COORD_BITS+14+7)/8)*8-1:0] m_axis_tdata
);
    import cpp_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int OW = 5 * CW + 14;
    localparam int OB = ((OW + 7) / 8) * 8;

    t_cmd    cmd;
    t_status status;
    logic signed [CW-1:0] px, py, pz;
    logic [IDX_BITS-1:0]  seg;
    logic [2*CW+3:0]      best_dist;

    cpp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_last      (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    cpp_dp #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_rst_n  (i_rst_n),
        .i_vx     (s_axis_tdata[0*CW +: CW]),
        .i_vy     (s_axis_tdata[1*CW +: CW]),
        .i_vz     (s_axis_tdata[2*CW +: CW]),
        .i_qx     (s_axis_tdata[3*CW +: CW]),
        .i_qy     (s_axis_tdata[4*CW +: CW]),
        .i_qz     (s_axis_tdata[5*CW +: CW]),
        .o_status (status),
        .o_px     (px),
        .o_py     (py),
        .o_pz     (pz),
        .o_seg    (seg),
        .o_dist   (best_dist)
    );

    // pack result
    assign m_axis_tdata = OB'({best_dist, seg, pz, py, px});

endmodule

[tb/nearest_point_checker.sv]
`timescale 1ns / 1ps

module nearest_point_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [143:0] i_s_tdata,
    input  logic         i_s_tlast,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [135:0] i_m_tdata,
    output int           o_error_count,
    output int           o_pending
);

    localparam int SEGMENT_LIMIT = cpp_pkg::MAX_VERTICES_DEF - 1;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [cpp_pkg::IDX_BITS-1:0]  seg;
        logic [cpp_pkg::DIST_BITS-1:0] sq_dist;
    } t_nearest;

    t_nearest nearest_q[$];

    // polyline search state
    longint prev_vtx[3];
    bit     have_prev;
    longint query_pt[3];
    longint best_pt[3];
    longint unsigned best_dist;
    bit     best_valid;
    int     best_seg;
    int     seg_count;

    // project the query onto segment a-b, clamped to its ends
    function automatic longint unsigned project_query(input longint a[3], input longint b[3],
                                                      output longint pt[3]);
        longint v[3];
        longint w[3];
        longint c1;
        longint c2;
        longint unsigned rem;
        longint unsigned frac;
        longint unsigned mag;
        longint unsigned rnd;
        longint unsigned sq_dist;
        longint d;
        c1 = 0;
        c2 = 0;
        sq_dist = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = b[i] - a[i];
            w[i] = query_pt[i] - a[i];
            c1 += w[i] * v[i];
            c2 += v[i] * v[i];
        end
        if (c1 <= 0) begin
            for (int i = 0; i < 3; i++) pt[i] = a[i];
        end else if (c2 <= c1) begin
            for (int i = 0; i < 3; i++) pt[i] = b[i];
        end else begin
            // restoring division for the Q0.32 fraction
            rem = c1;
            frac = 0;
            for (int k = 0; k < cpp_pkg::FRAC_BITS; k++) begin
                rem = rem << 1;
                frac = frac << 1;
                if (rem >= longint'(c2)) begin
                    rem -= c2;
                    frac |= 1;
                end
            end
            // round half away from zero on the magnitude
            for (int i = 0; i < 3; i++) begin
                mag = (v[i] < 0) ? -v[i] : v[i];
                rnd = (mag * frac + (64'd1 << 31)) >> 32;
                pt[i] = (v[i] < 0) ? a[i] - longint'(rnd) : a[i] + longint'(rnd);
            end
        end
        for (int i = 0; i < 3; i++) begin
            d = query_pt[i] - pt[i];
            sq_dist += d * d;
        end
        return sq_dist;
    endfunction

    function automatic void take_segment(input longint a[3], input longint b[3], input int idx);
        longint pt[3];
        longint unsigned sq_dist;
        sq_dist = project_query(a, b, pt);
        if (!best_valid || sq_dist < best_dist) begin
            best_valid = 1;
            best_dist = sq_dist;
            best_seg = idx;
            best_pt = pt;
        end
    endfunction

    // update the search with one accepted vertex request
    function automatic void absorb_vertex(input logic [143:0] data, input logic last);
        longint vtx[3];
        t_nearest res;
        for (int i = 0; i < 3; i++) vtx[i] = longint'($signed(data[24*i +: 24]));
        if (!have_prev) begin
            for (int i = 0; i < 3; i++) query_pt[i] = longint'($signed(data[72 + 24*i +: 24]));
            best_valid = 0;
            best_seg = 0;
            best_dist = 0;
            seg_count = 0;
            if (last) begin
                take_segment(vtx, vtx, 0);
            end else begin
                prev_vtx = vtx;
                have_prev = 1;
                return;
            end
        end else if (seg_count < SEGMENT_LIMIT) begin
            take_segment(prev_vtx, vtx, seg_count);
            seg_count++;
            prev_vtx = vtx;
        end
        if (!last) return;
        have_prev = 0;
        res.x = best_pt[0][23:0];
        res.y = best_pt[1][23:0];
        res.z = best_pt[2][23:0];
        res.seg = best_seg[9:0];
        res.sq_dist = best_dist[51:0];
        nearest_q.push_back(res);
    endfunction

    initial begin
        o_error_count = 0;
        o_pending = 0;
        have_prev = 0;
        best_valid = 0;
        seg_count = 0;
    end

    // watch both channels
    always @(posedge i_clk) begin
        t_nearest want;
        t_nearest got;
        if (i_rst_n && i_s_tvalid && i_s_tready) absorb_vertex(i_s_tdata, i_s_tlast);
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            got = {i_m_tdata[23:0], i_m_tdata[47:24], i_m_tdata[71:48],
                   i_m_tdata[81:72], i_m_tdata[133:82]};
            if (nearest_q.size() == 0) begin
                $error("result with nothing expected");
                o_error_count++;
            end else begin
                want = nearest_q.pop_front();
                if (got.x !== want.x) begin
                    $error("nearest_x exp %0d got %0d", want.x, got.x);
                    o_error_count++;
                end
                if (got.y !== want.y) begin
                    $error("nearest_y exp %0d got %0d", want.y, got.y);
                    o_error_count++;
                end
                if (got.z !== want.z) begin
                    $error("nearest_z exp %0d got %0d", want.z, got.z);
                    o_error_count++;
                end
                if (got.seg !== want.seg) begin
                    $error("segment_index exp %0d got %0d", want.seg, got.seg);
                    o_error_count++;
                end
                if (got.sq_dist !== want.sq_dist) begin
                    $error("squared_distance exp %0d got %0d", want.sq_dist, got.sq_dist);
                    o_error_count++;
                end
            end
        end
        o_pending = nearest_q.size();
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1300;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // vertex_x, vertex_y, vertex_z, query_x, query_y, query_z
    logic [143:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // nearest_x, nearest_y, nearest_z, segment_index, squared_distance, zero pad
    logic [135:0] m_axis_tdata;

    int  error_count;
    int  pending;
    bit  hold_request;
    int  idle_cycles;
    int  sent;

    closest_point_on_polyline_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    nearest_point_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tlast     (s_axis_tlast),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    // clock
    initial i_clk = 0;
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // watchdog on cycles without any request moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        m_axis_tready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_request) begin
                m_axis_tready <= 0;
                repeat (400) @(posedge i_clk);
                hold_request = 0;
            end
            gap = $urandom_range(0, 3);
            if (gap > 0) begin
                m_axis_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    function automatic logic [23:0] pick_coord(input int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 4000)) - 24'd2000;
            2: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            default: return 24'($urandom_range(0, 64)) - 24'd32;
        endcase
    endfunction

    task automatic send_vertex(input logic [23:0] vx, vy, vz, qx, qy, qz, input logic last);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {qz, qy, qx, vz, vy, vx};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // one polyline with random content in a single coordinate mode mostly
    task automatic send_polyline(input int count, input bit planar);
        int mode;
        logic [23:0] qx, qy, qz;
        mode = $urandom_range(0, 9);
        mode = (mode < 2) ? 0 : (mode < 7) ? 1 : (mode < 8) ? 2 : 3;
        qx = pick_coord(mode);
        qy = pick_coord(mode);
        qz = planar ? 24'd0 : pick_coord(mode);
        for (int i = 0; i < count; i++) begin
            send_vertex(pick_coord(mode), pick_coord(mode),
                        planar ? 24'd0 : pick_coord(mode),
                        (i == 0) ? qx : pick_coord(0), (i == 0) ? qy : pick_coord(0),
                        (i == 0) ? qz : pick_coord(0), i == count - 1);
        end
    endtask

    initial begin
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tlast = 0;
        hold_request = 0;
        idle_cycles = 0;
        sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // single vertex at the extremes and at the origin
        send_vertex(24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 1);
        send_vertex(24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h7fffff, 1);
        send_vertex(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1);
        // zero-length segment
        send_vertex(24'd100, 24'd200, 24'd0, 24'd500, 24'd500, 24'd0, 0);
        send_vertex(24'd100, 24'd200, 24'd0, 24'd1, 24'd1, 24'd1, 1);
        // clamp before a, interior, clamp past b
        send_vertex(24'd0, 24'd0, 24'd0, -24'd50, 24'd10, 24'd0, 0);
        send_vertex(24'd300, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1);
        send_vertex(24'd0, 24'd0, 24'd0, 24'd77, 24'd31, 24'd5, 0);
        send_vertex(24'd300, 24'd7, 24'd3, 24'd0, 24'd0, 24'd0, 1);
        send_vertex(24'd0, 24'd0, 24'd0, 24'd999, 24'd1, 24'd0, 0);
        send_vertex(24'd300, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1);
        // tie between two segments: earlier one kept
        send_vertex(-24'd100, 24'd0, 24'd0, 24'd0, 24'd50, 24'd0, 0);
        send_vertex(24'd0, 24'd0, 24'd0, 24'h7fffff, 24'h7fffff, 24'h7fffff, 0);
        send_vertex(24'd100, 24'd0, 24'd0, 24'h800000, 24'h800000, 24'h800000, 1);
        // full-span segment between opposite corners
        send_vertex(24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h800000, 24'd0, 0);
        send_vertex(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'd0, 24'd0, 24'd0, 1);
        send_vertex(24'h800000, 24'h7fffff, 24'd0, 24'd12345, -24'd54321, 24'd0, 0);
        send_vertex(24'h7fffff, 24'h800000, 24'd0, 24'd0, 24'd0, 24'd0, 1);

        // too many vertices: extra ones skipped, last still reports
        send_polyline(cpp_pkg::MAX_VERTICES_DEF + 6, 0);

        // pause until every result is out
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        wait (pending == 0);

        // long hold-off on the result side while polylines keep coming
        hold_request = 1;
        for (int i = 0; i < 6; i++) send_polyline($urandom_range(1, 3), 0);

        // random polylines
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                send_polyline($urandom_range(9, 40), $urandom_range(0, 1));
            else
                send_polyline($urandom_range(1, 8), $urandom_range(0, 3) == 0);
        end
        s_axis_tvalid <= 0;
        @(posedge i_clk);

        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

[files.f]
design/cpp_pkg.sv
design/cpp_ctrl.sv
design/cpp_dp.sv
design/closest_point_on_polyline_unit.sv
tb/nearest_point_checker.sv
tb/testbench.sv
